// ----- design/iosl_pkg.sv -----
// Shared types and constants for the indexed ordered slot list.
`default_nettype none

package iosl_pkg;

  localparam int SLOT_W  = 8;
  localparam int LEN_W   = 9;
  localparam logic [LEN_W-1:0] LEN_RESET = 9'd256;

  localparam logic OP_DELETE   = 1'b1;
  localparam logic STAT_DONE   = 1'b0;
  localparam logic STAT_RANGE  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_APPEND,
    ST_UNLINK,
    ST_CLEAR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic record;
    logic replace;
    logic add_new;
    logic del_start;
    logic append;
    logic unlink;
    logic clear_links;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic occupied;
    logic is_delete;
    logic value_zero;
    logic list_empty;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ----- design/iosl_if.sv -----
// Valid/ready channel interfaces for the request and result items.
`default_nettype none

interface iosl_in_if #(parameter int VALUE_WIDTH = 32);
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [iosl_pkg::SLOT_W-1:0] slot_index;
  logic [VALUE_WIDTH-1:0]      value_handle;

  modport source(output valid, operation, slot_index, value_handle, input ready);
  modport sink(input valid, operation, slot_index, value_handle, output ready);
endinterface

interface iosl_out_if;
  logic                        valid;
  logic                        ready;
  logic                        status;
  logic                        was_occupied;
  logic [iosl_pkg::SLOT_W-1:0] occupied_count;
  logic [iosl_pkg::SLOT_W-1:0] head_slot;
  logic [iosl_pkg::SLOT_W-1:0] tail_slot;

  modport source(output valid, status, was_occupied, occupied_count, head_slot, tail_slot,
                 input ready);
  modport sink(input valid, status, was_occupied, occupied_count, head_slot, tail_slot,
               output ready);
endinterface

`default_nettype wire

// ----- design/iosl_dpath.sv -----
// Datapath: slot memories, occupancy bits, list registers and result register.
`default_nettype none

module iosl_dpath #(
  parameter int MAX_SLOTS   = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire iosl_pkg::cmd_t              cmd,
  output iosl_pkg::stat_t                  stat,
  input  wire logic                        cfg_we,
  input  wire logic [iosl_pkg::LEN_W-1:0]  cfg_wdata,
  input  wire logic                        in_operation,
  input  wire logic [iosl_pkg::SLOT_W-1:0] in_slot_index,
  input  wire logic [VALUE_WIDTH-1:0]      in_value_handle,
  input  wire logic                        out_ready,
  output logic                             out_valid,
  output logic                             out_status,
  output logic                             out_was_occupied,
  output logic [iosl_pkg::SLOT_W-1:0]      out_occupied_count,
  output logic [iosl_pkg::SLOT_W-1:0]      out_head_slot,
  output logic [iosl_pkg::SLOT_W-1:0]      out_tail_slot
);
  import iosl_pkg::*;

  localparam int DEPTH = (MAX_SLOTS < (1 << SLOT_W)) ? MAX_SLOTS : (1 << SLOT_W);
  localparam int AW    = $clog2(DEPTH);

  // request registers
  logic                   op_r;
  logic [SLOT_W-1:0]      idx_r;
  logic [VALUE_WIDTH-1:0] val_r;

  // list state
  logic [LEN_W-1:0]  len_r;
  logic [SLOT_W-1:0] head_r;
  logic [SLOT_W-1:0] tail_r;
  logic [SLOT_W-1:0] count_r;
  logic [DEPTH-1:0]  occ_r;

  // link read data of the slot being deleted
  logic [SLOT_W-1:0] prev_rd_r;
  logic [SLOT_W-1:0] next_rd_r;

  // result staging and output register
  logic              status_r;
  logic              was_r;
  logic              out_valid_r;
  logic              out_status_r;
  logic              out_was_r;
  logic [SLOT_W-1:0] out_count_r;
  logic [SLOT_W-1:0] out_head_r;
  logic [SLOT_W-1:0] out_tail_r;

  logic [VALUE_WIDTH-1:0] value_mem [DEPTH];
  logic [SLOT_W-1:0]      prev_mem  [DEPTH];
  logic [SLOT_W-1:0]      next_mem  [DEPTH];

  logic [AW-1:0]     idx_a;
  logic              value_we;
  logic [VALUE_WIDTH-1:0] value_wd;
  logic              prev_we;
  logic [AW-1:0]     prev_wa;
  logic [SLOT_W-1:0] prev_wd;
  logic              next_we;
  logic [AW-1:0]     next_wa;
  logic [SLOT_W-1:0] next_wd;

  assign idx_a = idx_r[AW-1:0];

  always_comb begin
    stat.in_range   = (idx_r != '0) && ({1'b0, idx_r} < len_r) &&
                      (32'(idx_r) < 32'(MAX_SLOTS));
    stat.occupied   = occ_r[idx_a];
    stat.is_delete  = (op_r == OP_DELETE);
    stat.value_zero = (val_r == '0);
    stat.list_empty = (head_r == '0);
    stat.out_free   = !out_valid_r || out_ready;
  end

  // memory write ports; the commands never overlap
  always_comb begin
    value_we = cmd.replace || cmd.add_new || cmd.del_start;
    value_wd = cmd.del_start ? '0 : val_r;

    prev_we = 1'b0;
    prev_wa = idx_a;
    prev_wd = '0;
    if (cmd.add_new) begin
      prev_we = 1'b1;
      prev_wd = tail_r;
    end else if (cmd.unlink && next_rd_r != '0) begin
      prev_we = 1'b1;
      prev_wa = next_rd_r[AW-1:0];
      prev_wd = prev_rd_r;
    end else if (cmd.clear_links) begin
      prev_we = 1'b1;
    end

    next_we = 1'b0;
    next_wa = idx_a;
    next_wd = '0;
    if (cmd.add_new || cmd.clear_links) begin
      next_we = 1'b1;
    end else if (cmd.append) begin
      next_we = 1'b1;
      next_wa = tail_r[AW-1:0];
      next_wd = idx_r;
    end else if (cmd.unlink && prev_rd_r != '0) begin
      next_we = 1'b1;
      next_wa = prev_rd_r[AW-1:0];
      next_wd = next_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (value_we) value_mem[idx_a] <= value_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (next_we) next_mem[next_wa] <= next_wd;
    if (cmd.del_start) begin
      prev_rd_r <= prev_mem[idx_a];
      next_rd_r <= next_mem[idx_a];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= LEN_RESET;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) len_r <= cfg_wdata;
      if (cmd.add_new) begin
        occ_r[idx_a] <= 1'b1;
        count_r      <= count_r + SLOT_W'(1);
        if (stat.list_empty) begin
          head_r <= idx_r;
          tail_r <= idx_r;
        end
      end
      if (cmd.append) tail_r <= idx_r;
      if (cmd.del_start) begin
        occ_r[idx_a] <= 1'b0;
        count_r      <= count_r - SLOT_W'(1);
      end
      if (cmd.unlink) begin
        if (prev_rd_r == '0) head_r <= next_rd_r;
        if (next_rd_r == '0) tail_r <= prev_rd_r;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_operation;
      idx_r <= in_slot_index;
      val_r <= in_value_handle;
    end
    if (cmd.record) begin
      status_r <= stat.in_range ? STAT_DONE : STAT_RANGE;
      was_r    <= stat.in_range && stat.occupied;
    end
    if (cmd.load_out) begin
      out_status_r <= status_r;
      out_was_r    <= was_r;
      out_count_r  <= count_r;
      out_head_r   <= head_r;
      out_tail_r   <= tail_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_was_occupied   = out_was_r;
  assign out_occupied_count = out_count_r;
  assign out_head_slot      = out_head_r;
  assign out_tail_slot      = out_tail_r;

endmodule

`default_nettype wire

// ----- design/iosl_ctrl.sv -----
// Controller: sequences one item through execute, link update and result load.
`default_nettype none

module iosl_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire iosl_pkg::stat_t stat,
  output iosl_pkg::cmd_t       cmd
);
  import iosl_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        priority if (!stat.in_range) begin
          state_nxt = ST_DONE;
        end else if (stat.is_delete) begin
          state_nxt = stat.occupied ? ST_UNLINK : ST_DONE;
        end else if (stat.value_zero || stat.occupied || stat.list_empty) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_APPEND;
        end
      end
      ST_APPEND: state_nxt = ST_DONE;
      ST_UNLINK: state_nxt = ST_CLEAR;
      ST_CLEAR:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_EXEC: begin
        cmd.record    = 1'b1;
        cmd.del_start = stat.in_range && stat.is_delete && stat.occupied;
        cmd.replace   = stat.in_range && !stat.is_delete && !stat.value_zero &&
                        stat.occupied;
        cmd.add_new   = stat.in_range && !stat.is_delete && !stat.value_zero &&
                        !stat.occupied;
      end
      ST_APPEND: cmd.append      = 1'b1;
      ST_UNLINK: cmd.unlink      = 1'b1;
      ST_CLEAR:  cmd.clear_links = 1'b1;
      ST_DONE:   cmd.load_out    = stat.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/indexed_ordered_slot_list_unit.sv -----
// Sequence: accept, execute, then result load (range error, replace, ignored op); an
//   append to a non-empty list adds an append step, a delete of an occupied slot adds
//   unlink and clear steps; the load waits for a free output register. Items go one at a
//   time, taken only in IDLE; each link memory has one write port and a registered read.
// Reset (synchronous, rst_n low): list empty, all slots free, list_length 256, no result.
// Top level: controller plus datapath joined by command and status structs.
`default_nettype none

module indexed_ordered_slot_list_unit #(
  parameter int MAX_SLOTS   = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  iosl_in_if.sink                         in_chan,
  iosl_out_if.source                      out_chan,
  input  wire logic                       cfg_we,
  input  wire logic [iosl_pkg::LEN_W-1:0] cfg_wdata
);
  import iosl_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Controller: holds the item in IDLE until valid, then walks it through
  // execute, the optional link fix-up steps and the result load.
  iosl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: value and link memories, occupancy bits, head/tail/count
  // and the output register that frees the input side while a result waits.
  iosl_dpath #(
    .MAX_SLOTS   (MAX_SLOTS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_operation       (in_chan.operation),
    .in_slot_index      (in_chan.slot_index),
    .in_value_handle    (in_chan.value_handle),
    .out_ready          (out_chan.ready),
    .out_valid          (out_chan.valid),
    .out_status         (out_chan.status),
    .out_was_occupied   (out_chan.was_occupied),
    .out_occupied_count (out_chan.occupied_count),
    .out_head_slot      (out_chan.head_slot),
    .out_tail_slot      (out_chan.tail_slot)
  );

endmodule

`default_nettype wire
